// ----- src/afc_pkg.sv -----
// Shared types and constants for the angular Fourier coefficient block.
// No dependencies; imported by every module of the block.
package afc_pkg;

    // Input and result field widths
    localparam int BIN_W    = 6;
    localparam int HARM_W   = 5;
    localparam int WEIGHT_W = 24;
    localparam int COEF_W   = 48;

    // Trig entries are Q1.15; a weight times an entry fits 40 signed bits
    localparam int Q15_W  = 16;
    localparam int PROD_W = WEIGHT_W + Q15_W;

    // Default grid shape
    localparam int AZIMUTH_BINS_DEF = 64;
    localparam int POLAR_BINS_DEF   = 64;

    // Op codes
    localparam logic OP_STORE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Configuration port: one register, byte address 4*index
    localparam int              CFG_ADDR_W           = 3;
    localparam int              CFG_DATA_W           = 32;
    localparam logic            CFG_IDX_MAX_HARMONIC = 1'b0;
    localparam logic [HARM_W-1:0] MAX_HARMONIC_RST   = 5'd8;

    // Fixed-point angle constants
    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [31:0] PI_Q30      = 32'd3373259426;
    localparam logic [47:0] MAG_MAX     = 48'hFFFF_FFFF_FFFF;

    // Scaled magnitude plus rounding offset stays below 2^45
    localparam int SCALE_W = 45;

    typedef struct packed {
        logic acc_clear;   // zero both accumulators
        logic issue;       // one grid cell enters the MAC pipeline
    } mac_ctrl_t;

endpackage

// ----- src/afc_trig_rom.sv -----
// Cosine/sine lookup: 2N entries of Q1.15 for the angles pi*p/N.
// Entries are built at elaboration from Q30 Taylor polynomials; uses afc_pkg.
module afc_trig_rom #(
    parameter int AZIMUTH_BINS = afc_pkg::AZIMUTH_BINS_DEF
) (
    input  logic                                  aclk,
    input  logic [$clog2(2*AZIMUTH_BINS)-1:0]     ph,
    output logic signed [afc_pkg::Q15_W-1:0]      cos_q,
    output logic signed [afc_pkg::Q15_W-1:0]      sin_q
);
    import afc_pkg::*;

    localparam int TWO_N = 2 * AZIMUTH_BINS;

    logic signed [Q15_W-1:0] cos_rom [TWO_N];
    logic signed [Q15_W-1:0] sin_rom [TWO_N];
    logic signed [Q15_W-1:0] cos_reg;
    logic signed [Q15_W-1:0] sin_reg;

    for (genvar p = 0; p < TWO_N; p++) begin : g_ent
        localparam logic [63:0] QUARTER = 64'(2 * AZIMUTH_BINS);
        localparam logic [63:0] U       = 64'(4 * p);
        localparam logic [63:0] QUAD    = U / QUARTER;
        localparam logic [63:0] R       = U % QUARTER;
        localparam logic [63:0] A       = R * HALF_PI_Q30 / QUARTER;
        localparam logic [63:0] X2      = (A * A) >> 30;
        // sine polynomial, innermost term first
        localparam logic [63:0] S1 = Q30_ONE - ((X2 * Q30_ONE) >> 30) / 156;
        localparam logic [63:0] S2 = Q30_ONE - ((X2 * S1) >> 30) / 110;
        localparam logic [63:0] S3 = Q30_ONE - ((X2 * S2) >> 30) / 72;
        localparam logic [63:0] S4 = Q30_ONE - ((X2 * S3) >> 30) / 42;
        localparam logic [63:0] S5 = Q30_ONE - ((X2 * S4) >> 30) / 20;
        localparam logic [63:0] S6 = Q30_ONE - ((X2 * S5) >> 30) / 6;
        localparam logic [63:0] SV = (A * S6) >> 30;
        // cosine polynomial
        localparam logic [63:0] C1 = Q30_ONE - ((X2 * Q30_ONE) >> 30) / 132;
        localparam logic [63:0] C2 = Q30_ONE - ((X2 * C1) >> 30) / 90;
        localparam logic [63:0] C3 = Q30_ONE - ((X2 * C2) >> 30) / 56;
        localparam logic [63:0] C4 = Q30_ONE - ((X2 * C3) >> 30) / 30;
        localparam logic [63:0] C5 = Q30_ONE - ((X2 * C4) >> 30) / 12;
        localparam logic [63:0] DV = ((X2 * C5) >> 30) / 2;
        localparam logic [63:0] CV = (DV >= Q30_ONE) ? 64'd0 : Q30_ONE - DV;
        // round to Q1.15
        localparam logic [63:0] CR = (CV * 64'd32767 + 64'd536870912) >> 30;
        localparam logic [63:0] SR = (SV * 64'd32767 + 64'd536870912) >> 30;
        localparam logic signed [Q15_W-1:0] CQ = Q15_W'(CR);
        localparam logic signed [Q15_W-1:0] SQ = Q15_W'(SR);
        // mirror into the quadrant
        localparam logic signed [Q15_W-1:0] COS_E =
            (QUAD == 64'd0) ? CQ : (QUAD == 64'd1) ? -SQ : (QUAD == 64'd2) ? -CQ : SQ;
        localparam logic signed [Q15_W-1:0] SIN_E =
            (QUAD == 64'd0) ? SQ : (QUAD == 64'd1) ? CQ : (QUAD == 64'd2) ? -SQ : -CQ;

        assign cos_rom[p] = COS_E;
        assign sin_rom[p] = SIN_E;
    end

    always_ff @(posedge aclk) begin
        cos_reg <= cos_rom[ph];
        sin_reg <= sin_rom[ph];
    end

    assign cos_q = cos_reg;
    assign sin_q = sin_reg;

endmodule

// ----- src/afc_mac.sv -----
// Weight grid memory and the shared two-lane multiply-accumulate unit.
// Uses afc_pkg and afc_trig_rom.
module afc_mac #(
    parameter int AZIMUTH_BINS = afc_pkg::AZIMUTH_BINS_DEF,
    parameter int POLAR_BINS   = afc_pkg::POLAR_BINS_DEF
) (
    input  logic                                               aclk,
    input  logic                                               aresetn,
    input  afc_pkg::mac_ctrl_t                                 ctrl,
    input  logic [$clog2(AZIMUTH_BINS*POLAR_BINS)-1:0]         rd_addr,
    input  logic [$clog2(2*AZIMUTH_BINS)-1:0]                  ph,
    input  logic                                               wr_en,
    input  logic [$clog2(AZIMUTH_BINS*POLAR_BINS)-1:0]         wr_addr,
    input  logic signed [afc_pkg::WEIGHT_W-1:0]                wr_data,
    output logic                                               busy,
    output logic signed [afc_pkg::PROD_W+$clog2(AZIMUTH_BINS)-1:0] cos_sum,
    output logic signed [afc_pkg::PROD_W+$clog2(AZIMUTH_BINS)-1:0] sin_sum
);
    import afc_pkg::*;

    localparam int DEPTH = AZIMUTH_BINS * POLAR_BINS;
    localparam int ACC_W = PROD_W + $clog2(AZIMUTH_BINS);

    logic signed [WEIGHT_W-1:0] grid_mem [DEPTH];
    logic signed [WEIGHT_W-1:0] w_reg;
    logic signed [Q15_W-1:0]    cos_q;
    logic signed [Q15_W-1:0]    sin_q;
    logic signed [PROD_W-1:0]   pc_reg;
    logic signed [PROD_W-1:0]   ps_reg;
    logic signed [ACC_W-1:0]    cacc_reg;
    logic signed [ACC_W-1:0]    sacc_reg;
    logic                       v1_reg;
    logic                       v2_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            grid_mem[wr_addr] <= wr_data;
        end
        w_reg <= grid_mem[rd_addr];
    end

    afc_trig_rom #(
        .AZIMUTH_BINS(AZIMUTH_BINS)
    ) u_rom (
        .aclk  (aclk),
        .ph    (ph),
        .cos_q (cos_q),
        .sin_q (sin_q)
    );

    // weight and table entry arrive together in the cycle after issue
    always_ff @(posedge aclk) begin
        pc_reg <= PROD_W'(w_reg) * PROD_W'(cos_q);
        ps_reg <= PROD_W'(w_reg) * PROD_W'(sin_q);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= ctrl.issue;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.acc_clear) begin
            cacc_reg <= '0;
            sacc_reg <= '0;
        end else if (v2_reg) begin
            cacc_reg <= cacc_reg + ACC_W'(pc_reg);
            sacc_reg <= sacc_reg + ACC_W'(ps_reg);
        end
    end

    assign busy    = v1_reg | v2_reg;
    assign cos_sum = cacc_reg;
    assign sin_sum = sacc_reg;

endmodule

// ----- src/afc_scaler.sv -----
// Scales both sums by 2*pi/N with rounding: one 32x32 multiplier, shared by the two
// lanes and (N not a power of 2) a divide by N, a quotient byte per pass. Uses afc_pkg.
module afc_scaler #(
    parameter int AZIMUTH_BINS = afc_pkg::AZIMUTH_BINS_DEF
) (
    input  logic                                                   aclk,
    input  logic                                                   aresetn,
    input  logic                                                   start,
    input  logic signed [afc_pkg::PROD_W+$clog2(AZIMUTH_BINS)-1:0] cos_sum,
    input  logic signed [afc_pkg::PROD_W+$clog2(AZIMUTH_BINS)-1:0] sin_sum,
    output logic                                                   done,
    output logic signed [afc_pkg::COEF_W-1:0]                      cos_res,
    output logic signed [afc_pkg::COEF_W-1:0]                      sin_res
);
    import afc_pkg::*;

    localparam int   ACC_W  = PROD_W + $clog2(AZIMUTH_BINS);
    localparam int   MW     = (ACC_W > COEF_W) ? ACC_W : COEF_W;
    localparam int   LOG2N  = $clog2(AZIMUTH_BINS);
    localparam int   RW     = LOG2N;
    localparam int   DIG_W  = 8;
    localparam int   DIGITS = (SCALE_W + DIG_W - 1) / DIG_W;
    localparam int   DW     = DIGITS * DIG_W;
    localparam int   TW     = RW + DIG_W;
    localparam int   RSH    = TW + LOG2N;
    localparam int   CW     = $clog2(DIGITS);
    localparam int   HALF_N = AZIMUTH_BINS / 2;
    localparam bit   N_POW2 = (AZIMUTH_BINS & (AZIMUTH_BINS - 1)) == 0;
    // ceil(2^RSH / N): exact floor division of any partial remainder below 2^TW
    localparam logic [31:0] RECIP =
        32'(((64'd1 << RSH) + 64'(AZIMUTH_BINS) - 64'd1) / 64'(AZIMUTH_BINS));

    localparam logic [2:0] SC_IDLE  = 3'd0;
    localparam logic [2:0] SC_ABS   = 3'd1;
    localparam logic [2:0] SC_MLO   = 3'd2;
    localparam logic [2:0] SC_MHI   = 3'd3;
    localparam logic [2:0] SC_SUM   = 3'd4;
    localparam logic [2:0] SC_DIV   = 3'd5;
    localparam logic [2:0] SC_STORE = 3'd6;
    localparam logic [2:0] SC_DIGIT = 3'd7;

    logic [2:0]               state_reg, state_next;
    logic                     lane_reg, lane_next;
    logic                     neg_reg, neg_next;
    logic [COEF_W-1:0]        m_reg, m_next;
    logic [63:0]              prod_reg, prod_next;
    logic [31:0]              plo_reg, plo_next;
    logic [DW-1:0]            d_reg, d_next;
    logic [RW-1:0]            rem_reg, rem_next;
    logic [CW-1:0]            cnt_reg, cnt_next;
    logic signed [COEF_W-1:0] cres_reg, cres_next;
    logic signed [COEF_W-1:0] sres_reg, sres_next;
    logic                     done_reg, done_next;

    logic signed [ACC_W-1:0]  sel_sum;
    logic [MW-1:0]            sum_x;
    logic [MW-1:0]            mag;
    logic [31:0]              mul_a;
    logic [31:0]              mul_b;
    logic [63:0]              prod;
    logic [TW-1:0]            trial;
    logic [DIG_W-1:0]         qd;
    logic [TW-1:0]            qn;
    logic [COEF_W-1:0]        res;

    assign sel_sum = lane_reg ? sin_sum : cos_sum;
    assign sum_x   = MW'(sel_sum);
    assign mag     = sel_sum[ACC_W-1] ? (~sum_x + MW'(1)) : sum_x;

    // the one multiplier: low 16 bits of the magnitude, then the high 32 bits, then
    // the reciprocal of N against each partial remainder
    assign mul_a = (state_reg == SC_MLO) ? 32'(m_reg[15:0]) :
                   (state_reg == SC_DIV) ? 32'(trial) : m_reg[COEF_W-1:16];
    assign mul_b = (state_reg == SC_DIV) ? RECIP : PI_Q30;
    assign prod  = 64'(mul_a) * 64'(mul_b);

    // next quotient byte and what it takes off the partial remainder
    assign trial = {rem_reg, d_reg[DW-1 -: DIG_W]};
    assign qd    = prod_reg[RSH +: DIG_W];
    assign qn    = TW'(qd) * TW'(AZIMUTH_BINS);
    assign res   = neg_reg ? (~COEF_W'(d_reg) + COEF_W'(1)) : COEF_W'(d_reg);

    always_comb begin
        state_next = state_reg;
        lane_next  = lane_reg;
        neg_next   = neg_reg;
        m_next     = m_reg;
        prod_next  = prod_reg;
        plo_next   = plo_reg;
        d_next     = d_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        cres_next  = cres_reg;
        sres_next  = sres_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            SC_IDLE: begin
                if (start) begin
                    lane_next  = 1'b0;
                    state_next = SC_ABS;
                end
            end
            SC_ABS: begin
                neg_next   = sel_sum[ACC_W-1];
                m_next     = (mag > MW'(MAG_MAX)) ? MAG_MAX : mag[COEF_W-1:0];
                state_next = SC_MLO;
            end
            SC_MLO: begin
                prod_next  = prod;
                state_next = SC_MHI;
            end
            SC_MHI: begin
                plo_next   = prod_reg[47:16];
                prod_next  = prod;
                state_next = SC_SUM;
            end
            SC_SUM: begin
                d_next     = DW'(SCALE_W'((prod_reg + 64'(plo_reg)) >> 20) + SCALE_W'(HALF_N));
                rem_next   = '0;
                cnt_next   = '0;
                state_next = SC_DIV;
            end
            SC_DIV: begin
                if (N_POW2) begin
                    d_next     = d_reg >> LOG2N;
                    state_next = SC_STORE;
                end else begin
                    prod_next  = prod;
                    state_next = SC_DIGIT;
                end
            end
            SC_DIGIT: begin
                // shift the quotient byte in, keep the remainder for the next byte
                rem_next = RW'(trial - qn);
                d_next   = {d_reg[DW-DIG_W-1:0], qd};
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(DIGITS - 1)) begin
                    state_next = SC_STORE;
                end else begin
                    state_next = SC_DIV;
                end
            end
            SC_STORE: begin
                if (!lane_reg) begin
                    cres_next  = res;
                    lane_next  = 1'b1;
                    state_next = SC_ABS;
                end else begin
                    sres_next  = res;
                    done_next  = 1'b1;
                    state_next = SC_IDLE;
                end
            end
            default: state_next = SC_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SC_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        lane_reg <= lane_next;
        neg_reg  <= neg_next;
        m_reg    <= m_next;
        prod_reg <= prod_next;
        plo_reg  <= plo_next;
        d_reg    <= d_next;
        rem_reg  <= rem_next;
        cnt_reg  <= cnt_next;
        cres_reg <= cres_next;
        sres_reg <= sres_next;
    end

    assign done    = done_reg;
    assign cos_res = cres_reg;
    assign sin_res = sres_reg;

endmodule

// ----- src/afc_seq.sv -----
// Sequencer: takes requests, reduces the starting phase, walks one grid row
// through the MAC, then runs the scaler and hands the result out. Uses afc_pkg.
module afc_seq #(
    parameter int AZIMUTH_BINS = afc_pkg::AZIMUTH_BINS_DEF,
    parameter int POLAR_BINS   = afc_pkg::POLAR_BINS_DEF
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        s_valid,
    input  logic                                        s_op,
    input  logic [afc_pkg::BIN_W-1:0]                   s_polar_bin,
    input  logic [afc_pkg::HARM_W-1:0]                  s_harmonic,
    input  logic [afc_pkg::HARM_W-1:0]                  max_harmonic,
    output logic                                        s_ready,
    output afc_pkg::mac_ctrl_t                          mac_ctrl,
    input  logic                                        mac_busy,
    output logic [$clog2(AZIMUTH_BINS*POLAR_BINS)-1:0]  rd_addr,
    output logic [$clog2(2*AZIMUTH_BINS)-1:0]           ph,
    output logic                                        scale_start,
    input  logic                                        scale_done,
    input  logic                                        out_free,
    output logic                                        out_load,
    output logic                                        bad
);
    import afc_pkg::*;

    localparam int TWO_N = 2 * AZIMUTH_BINS;
    localparam int AW    = $clog2(AZIMUTH_BINS * POLAR_BINS);
    localparam int IW    = $clog2(AZIMUTH_BINS);
    localparam int PHW   = $clog2(TWO_N);
    localparam int PW    = ((PHW > 6) ? PHW : 6) + 1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_REDUCE = 3'd1;
    localparam logic [2:0] S_WALK   = 3'd2;
    localparam logic [2:0] S_DRAIN  = 3'd3;
    localparam logic [2:0] S_SCALE  = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0]     state_reg, state_next;
    logic [IW-1:0]  cnt_reg, cnt_next;
    logic [PHW-1:0] ph_reg, ph_next;
    logic [PW-1:0]  base_reg, base_next;
    logic [PW-1:0]  step_reg, step_next;
    logic [AW-1:0]  row_reg, row_next;
    logic           row_ok_reg, row_ok_next;
    logic           bad_reg, bad_next;

    logic           base_hi;
    logic           step_hi;
    logic [PHW:0]   ph_sum;

    assign base_hi = base_reg >= PW'(TWO_N);
    assign step_hi = step_reg >= PW'(TWO_N);
    assign ph_sum  = {1'b0, ph_reg} + (PHW+1)'(step_reg);

    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        ph_next     = ph_reg;
        base_next   = base_reg;
        step_next   = step_reg;
        row_next    = row_reg;
        row_ok_next = row_ok_reg;
        bad_next    = bad_reg;
        mac_ctrl    = '0;
        scale_start = 1'b0;
        out_load    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid && s_op == OP_QUERY) begin
                    mac_ctrl.acc_clear = 1'b1;
                    cnt_next    = '0;
                    row_ok_next = 32'(s_polar_bin) < POLAR_BINS;
                    row_next    = AW'(s_polar_bin) * AW'(AZIMUTH_BINS);
                    // phase of bin 0 is q*(N+1); q*N is N for odd q, else 0
                    base_next   = PW'(s_harmonic) + (s_harmonic[0] ? PW'(AZIMUTH_BINS) : '0);
                    step_next   = PW'({s_harmonic, 1'b0});
                    if (s_harmonic > max_harmonic) begin
                        bad_next   = 1'b1;
                        state_next = S_DONE;
                    end else begin
                        bad_next   = 1'b0;
                        state_next = S_REDUCE;
                    end
                end
            end
            S_REDUCE: begin
                // bring start phase and step below 2N
                if (base_hi) begin
                    base_next = base_reg - PW'(TWO_N);
                end
                if (step_hi) begin
                    step_next = step_reg - PW'(TWO_N);
                end
                if (!base_hi && !step_hi) begin
                    ph_next = base_reg[PHW-1:0];
                    if (row_ok_reg) begin
                        state_next = S_WALK;
                    end else begin
                        scale_start = 1'b1;
                        state_next  = S_SCALE;
                    end
                end
            end
            S_WALK: begin
                mac_ctrl.issue = 1'b1;
                cnt_next = cnt_reg + IW'(1);
                ph_next  = (ph_sum >= (PHW+1)'(TWO_N)) ?
                           PHW'(ph_sum - (PHW+1)'(TWO_N)) : ph_sum[PHW-1:0];
                if (cnt_reg == IW'(AZIMUTH_BINS - 1)) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!mac_busy) begin
                    scale_start = 1'b1;
                    state_next  = S_SCALE;
                end
            end
            S_SCALE: begin
                if (scale_done) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg    <= cnt_next;
        ph_reg     <= ph_next;
        base_reg   <= base_next;
        step_reg   <= step_next;
        row_reg    <= row_next;
        row_ok_reg <= row_ok_next;
        bad_reg    <= bad_next;
    end

    assign s_ready = state_reg == S_IDLE;
    assign rd_addr = row_reg + AW'(cnt_reg);
    assign ph      = ph_reg;
    assign bad     = bad_reg;

endmodule

// ----- src/angular_fourier_coefficients.sv -----
// Top level of the angular Fourier coefficient block: config register,
// store path, result register. Uses afc_pkg, afc_seq, afc_mac, afc_scaler.
//
//  channel  | handshake           | payload
//  ---------+---------------------+-----------------------------------------------
//  s_       | s_valid / s_ready   | op, azimuth_bin, polar_bin, harmonic, weight
//  m_       | m_valid / m_ready   | cos_coef, sin_coef, bad_harmonic
//  apb      | psel/penable/pready | paddr, pwrite, pwdata, prdata (max_harmonic)
//
// A store request leaves s_ready high.
// A query's result turns valid after the row walk through the single grid read
// port and shared MAC and the scaling of both sums; when AZIMUTH_BINS is not a
// power of two, the scaler divides by N byte-wise through the shared multiplier.
// Phase reduction subtracts 2N from the start phase and the phase step until
// both are below 2N (repeatedly only for small N).
// A harmonic above max_harmonic skips the walk and the scaler and returns with
// zero coefficients and m_bad_harmonic set.
// s_ready drops while a query is at work; a stalled result holds in the output
// register and the block stays busy only if the next query finishes first.
module angular_fourier_coefficients #(
    parameter int AZIMUTH_BINS = afc_pkg::AZIMUTH_BINS_DEF,
    parameter int POLAR_BINS   = afc_pkg::POLAR_BINS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // request channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_op,
    input  logic [afc_pkg::BIN_W-1:0]           s_azimuth_bin,
    input  logic [afc_pkg::BIN_W-1:0]           s_polar_bin,
    input  logic [afc_pkg::HARM_W-1:0]          s_harmonic,
    input  logic signed [afc_pkg::WEIGHT_W-1:0] s_weight,
    // result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [afc_pkg::COEF_W-1:0]   m_cos_coef,
    output logic signed [afc_pkg::COEF_W-1:0]   m_sin_coef,
    output logic                                m_bad_harmonic,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [afc_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [afc_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [afc_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                pready
);
    import afc_pkg::*;

    localparam int AW    = $clog2(AZIMUTH_BINS * POLAR_BINS);
    localparam int ACC_W = PROD_W + $clog2(AZIMUTH_BINS);

    logic [HARM_W-1:0]        max_harm_reg;
    logic                     cfg_hit;

    mac_ctrl_t                mac_ctrl;
    logic                     mac_busy;
    logic [AW-1:0]            rd_addr;
    logic [$clog2(2*AZIMUTH_BINS)-1:0] ph;
    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic signed [ACC_W-1:0]  cos_sum;
    logic signed [ACC_W-1:0]  sin_sum;
    logic                     scale_start;
    logic                     scale_done;
    logic signed [COEF_W-1:0] cos_res;
    logic signed [COEF_W-1:0] sin_res;
    logic                     out_free;
    logic                     out_load;
    logic                     bad;

    logic                     m_valid_reg;
    logic signed [COEF_W-1:0] m_cos_reg;
    logic signed [COEF_W-1:0] m_sin_reg;
    logic                     m_bad_reg;

    // ---- configuration register: index is paddr bit 2, data in the low bits
    assign pready  = 1'b1;
    assign cfg_hit = paddr[2] == CFG_IDX_MAX_HARMONIC;
    assign prdata  = cfg_hit ? CFG_DATA_W'(max_harm_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_harm_reg <= MAX_HARMONIC_RST;
        end else if (psel && penable && pwrite && pready && cfg_hit) begin
            max_harm_reg <= pwdata[HARM_W-1:0];
        end
    end

    // ---- store path: write the cell on accept, drop stores outside the grid
    assign wr_en   = s_valid && s_ready && (s_op == OP_STORE)
                     && (32'(s_azimuth_bin) < AZIMUTH_BINS)
                     && (32'(s_polar_bin) < POLAR_BINS);
    assign wr_addr = AW'(s_polar_bin) * AW'(AZIMUTH_BINS) + AW'(s_azimuth_bin);

    afc_seq #(
        .AZIMUTH_BINS(AZIMUTH_BINS),
        .POLAR_BINS  (POLAR_BINS)
    ) u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_op         (s_op),
        .s_polar_bin  (s_polar_bin),
        .s_harmonic   (s_harmonic),
        .max_harmonic (max_harm_reg),
        .s_ready      (s_ready),
        .mac_ctrl     (mac_ctrl),
        .mac_busy     (mac_busy),
        .rd_addr      (rd_addr),
        .ph           (ph),
        .scale_start  (scale_start),
        .scale_done   (scale_done),
        .out_free     (out_free),
        .out_load     (out_load),
        .bad          (bad)
    );

    afc_mac #(
        .AZIMUTH_BINS(AZIMUTH_BINS),
        .POLAR_BINS  (POLAR_BINS)
    ) u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (mac_ctrl),
        .rd_addr (rd_addr),
        .ph      (ph),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (s_weight),
        .busy    (mac_busy),
        .cos_sum (cos_sum),
        .sin_sum (sin_sum)
    );

    afc_scaler #(
        .AZIMUTH_BINS(AZIMUTH_BINS)
    ) u_scaler (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (scale_start),
        .cos_sum (cos_sum),
        .sin_sum (sin_sum),
        .done    (scale_done),
        .cos_res (cos_res),
        .sin_res (sin_res)
    );

    // ---- result register: load when empty or being drained this cycle
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_cos_reg <= bad ? '0 : cos_res;
            m_sin_reg <= bad ? '0 : sin_res;
            m_bad_reg <= bad;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_cos_coef     = m_cos_reg;
    assign m_sin_coef     = m_sin_reg;
    assign m_bad_harmonic = m_bad_reg;

endmodule

// ----- src/afc_checker.sv -----
// Port-level checks for angular_fourier_coefficients, attached by bind.
// Uses afc_pkg.
module afc_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic                                s_op,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic signed [afc_pkg::COEF_W-1:0]   m_cos_coef,
    input logic signed [afc_pkg::COEF_W-1:0]   m_sin_coef,
    input logic                                m_bad_harmonic
);
    import afc_pkg::*;

    // a query occupies the block for at least the next cycle
    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_op == OP_QUERY |=> !s_ready)
        else $error("s_ready stayed high after a query request");

    // a store completes in its own cycle
    a_store_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_op == OP_STORE |=> s_ready)
        else $error("s_ready dropped after a store request");

    // a rejected harmonic carries zero coefficients
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_bad_harmonic |-> m_cos_coef == '0 && m_sin_coef == '0)
        else $error("bad harmonic result with nonzero coefficients");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_cos_coef) && $stable(m_sin_coef))
        else $error("result changed while stalled");

endmodule

bind angular_fourier_coefficients afc_checker u_afc_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .s_op           (s_op),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_cos_coef     (m_cos_coef),
    .m_sin_coef     (m_sin_coef),
    .m_bad_harmonic (m_bad_harmonic)
);

// ----- tb/angular_fourier_coefficients_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for angular_fourier_coefficients: directed and random store
// and query requests, checked against an in-bench coefficient predictor.
// Depends on afc_pkg and the angular_fourier_coefficients RTL only.
module angular_fourier_coefficients_test;

    // Grid shape and field widths follow the block's defaults
    localparam int AZ_BINS    = afc_pkg::AZIMUTH_BINS_DEF;
    localparam int POL_BINS   = afc_pkg::POLAR_BINS_DEF;
    localparam int TURN_STEPS = 2 * AZ_BINS;
    localparam int BIN_W      = afc_pkg::BIN_W;
    localparam int HARM_W     = afc_pkg::HARM_W;
    localparam int WEIGHT_W   = afc_pkg::WEIGHT_W;
    localparam int COEF_W     = afc_pkg::COEF_W;
    localparam int ADDR_W     = afc_pkg::CFG_ADDR_W;

    // Register index with no register behind it; writes there must do nothing
    localparam int IDX_SPARE = 1;

    // Fixed-point angle constants (Q30), coefficient and magnitude limits
    localparam longint unsigned ONE_Q30            = 64'd1073741824;
    localparam longint unsigned RIGHT_ANGLE_Q30    = 64'd1686629713;
    localparam longint unsigned STRAIGHT_ANGLE_Q30 = 64'd3373259426;
    localparam longint unsigned COEF_MAX           = 64'd140737488355327;
    localparam longint unsigned MAG_LIMIT          = 64'd281474976710656;

    localparam logic signed [WEIGHT_W-1:0] W_MAX = 24'sh7FFFFF;
    localparam logic signed [WEIGHT_W-1:0] W_MIN = 24'sh800000;

    // Settle for longer than a query takes at the default grid
    localparam int SETTLE_CYCLES = 100;
    // Longest correct quiet stretch is a query plus a long stall plus a settle
    localparam int STALL_LIMIT   = 4000;
    localparam int ERR_PRINT_MAX = 40;

    typedef struct {
        logic                       op;
        logic [BIN_W-1:0]           az;
        logic [BIN_W-1:0]           pol;
        logic [HARM_W-1:0]          harm;
        logic signed [WEIGHT_W-1:0] wt;
        bit                         hold;   // hold the request until all results are back
        int                         gap;    // idle cycles before the request goes out
    } request_t;

    typedef struct {
        logic [COEF_W-1:0] cos_v;
        logic [COEF_W-1:0] sin_v;
        logic              bad;
    } coef_set_t;

    // Clock, reset and block ports; every input starts at a known value
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                       s_valid       = 1'b0;
    logic                       s_ready;
    logic                       s_op          = afc_pkg::OP_STORE;
    logic [BIN_W-1:0]           s_azimuth_bin = '0;
    logic [BIN_W-1:0]           s_polar_bin   = '0;
    logic [HARM_W-1:0]          s_harmonic    = '0;
    logic signed [WEIGHT_W-1:0] s_weight      = '0;

    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic signed [COEF_W-1:0]   m_cos_coef;
    logic signed [COEF_W-1:0]   m_sin_coef;
    logic                       m_bad_harmonic;

    logic                            psel    = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite  = 1'b0;
    logic [ADDR_W-1:0]               paddr   = '0;
    logic [afc_pkg::CFG_DATA_W-1:0]  pwdata  = '0;
    logic [afc_pkg::CFG_DATA_W-1:0]  prdata;
    logic                            pready;

    // Predictor state: its own copy of the grid, the trig table and the limit
    int          cell_weight [POL_BINS][AZ_BINS];
    int          cos_q15 [TURN_STEPS];
    int          sin_q15 [TURN_STEPS];
    logic [HARM_W-1:0] harm_limit;

    // Stimulus side bookkeeping: which cells have been stored so far
    bit          stored_cell [POL_BINS][AZ_BINS];
    int          row_stored [POL_BINS];

    request_t    request_backlog[$];
    coef_set_t   expected_coefs[$];
    request_t    presented;
    coef_set_t   oldest;

    bit          tx_steady;
    bit          rx_steady;
    int          tx_wait;
    int          rx_stall;
    int          n_predicted = 0;   // written by the driver only
    int          n_checked   = 0;   // written by the monitor only, nonblocking
    int          n_errors    = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    angular_fourier_coefficients uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_azimuth_bin  (s_azimuth_bin),
        .s_polar_bin    (s_polar_bin),
        .s_harmonic     (s_harmonic),
        .s_weight       (s_weight),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_cos_coef     (m_cos_coef),
        .m_sin_coef     (m_sin_coef),
        .m_bad_harmonic (m_bad_harmonic),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // ------------------------------------------------------------------
    // Coefficient predictor
    // ------------------------------------------------------------------

    function automatic int q30_to_q15(longint unsigned v);
        return int'((v * 64'd32767 + 64'd536870912) >> 30);
    endfunction

    // Build the 2N-entry cos/sin table: Taylor series in Q30 on the first
    // quadrant, truncating every step, then mirror into the other quadrants.
    function automatic void build_angle_table();
        longint unsigned u, quad, r, a, x2, t, s, c, d;
        int cs, sn, p, k;
        for (p = 0; p < TURN_STEPS; p++) begin
            u    = 4 * p;
            quad = u / TURN_STEPS;
            r    = u % TURN_STEPS;
            a    = r * RIGHT_ANGLE_Q30 / TURN_STEPS;
            x2   = (a * a) >> 30;
            // sine nest divides by 13*12, 11*10, ... 3*2
            t = ONE_Q30;
            for (k = 0; k < 6; k++)
                t = ONE_Q30 - ((x2 * t) >> 30) / ((13 - 2 * k) * (12 - 2 * k));
            s = (a * t) >> 30;
            // cosine nest divides by 12*11, 10*9, ... 4*3, then the final half
            t = ONE_Q30;
            for (k = 0; k < 5; k++)
                t = ONE_Q30 - ((x2 * t) >> 30) / ((12 - 2 * k) * (11 - 2 * k));
            d  = ((x2 * t) >> 30) / 2;
            c  = (d >= ONE_Q30) ? 64'd0 : ONE_Q30 - d;
            cs = q30_to_q15(c);
            sn = q30_to_q15(s);
            case (quad[1:0])
                2'd0: begin cos_q15[p] = cs;  sin_q15[p] = sn;  end
                2'd1: begin cos_q15[p] = -sn; sin_q15[p] = cs;  end
                2'd2: begin cos_q15[p] = -cs; sin_q15[p] = -sn; end
                default: begin cos_q15[p] = sn; sin_q15[p] = -cs; end
            endcase
        end
    endfunction

    // Scale a Q.31 sum by 2*pi/N into Q24.24: work on the magnitude, round the
    // divide by N, put the sign back and saturate.
    function automatic logic [COEF_W-1:0] scale_to_q24(longint sum);
        bit neg;
        longint unsigned mag, v, r;
        longint res;
        neg = sum < 0;
        mag = neg ? longint'(-sum) : longint'(sum);
        if (mag >= MAG_LIMIT)
            mag = MAG_LIMIT - 1;
        v = ((mag >> 16) * STRAIGHT_ANGLE_Q30
             + (((mag & 64'hFFFF) * STRAIGHT_ANGLE_Q30) >> 16)) >> 20;
        r = (v + AZ_BINS / 2) / AZ_BINS;
        if (r > COEF_MAX)
            r = COEF_MAX;
        res = neg ? -longint'(r) : longint'(r);
        return res[COEF_W-1:0];
    endfunction

    // Apply one accepted request to the grid copy; a query queues its result
    function automatic void apply_request(request_t r);
        longint csum, ssum;
        int i, ph;
        coef_set_t res;
        csum = 0;
        ssum = 0;
        if (r.op == afc_pkg::OP_STORE) begin
            cell_weight[r.pol][r.az] = int'(r.wt);
            return;
        end
        n_predicted++;
        if (r.harm > harm_limit) begin
            res.cos_v = '0;
            res.sin_v = '0;
            res.bad   = 1'b1;
        end else begin
            for (i = 0; i < AZ_BINS; i++) begin
                ph   = (int'(r.harm) * (2 * i + 1 + AZ_BINS)) % TURN_STEPS;
                csum += longint'(cell_weight[r.pol][i]) * longint'(cos_q15[ph]);
                ssum += longint'(cell_weight[r.pol][i]) * longint'(sin_q15[ph]);
            end
            res.cos_v = scale_to_q24(csum);
            res.sin_v = scale_to_q24(ssum);
            res.bad   = 1'b0;
        end
        expected_coefs.push_back(res);
    endfunction

    // ------------------------------------------------------------------
    // Request generation
    // ------------------------------------------------------------------

    // Idle stretch: mostly short, now and then a long one
    function automatic int random_idle();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(20, 120);
        return $urandom_range(1, 3);
    endfunction

    function automatic int next_gap();
        if (tx_steady || $urandom_range(0, 99) < 55)
            return 0;
        return random_idle();
    endfunction

    function automatic logic signed [WEIGHT_W-1:0] rand_weight();
        case ($urandom_range(0, 11))
            0: return W_MAX;
            1: return W_MIN;
            2: return '0;
            default: return WEIGHT_W'($urandom);
        endcase
    endfunction

    // Store request; the unused harmonic field carries noise
    function automatic void add_store(int az, int pol, logic signed [WEIGHT_W-1:0] w,
                                      bit hold);
        request_t r;
        r.op   = afc_pkg::OP_STORE;
        r.az   = BIN_W'(az);
        r.pol  = BIN_W'(pol);
        r.harm = HARM_W'($urandom);
        r.wt   = w;
        r.hold = hold || ($urandom_range(0, 59) == 0);
        r.gap  = next_gap();
        if (!stored_cell[pol][az]) begin
            stored_cell[pol][az] = 1'b1;
            row_stored[pol]++;
        end
        request_backlog.push_back(r);
    endfunction

    // Query request; azimuth and weight fields carry noise
    function automatic void add_query(int pol, int q, bit hold);
        request_t r;
        r.op   = afc_pkg::OP_QUERY;
        r.az   = BIN_W'($urandom);
        r.pol  = BIN_W'(pol);
        r.harm = HARM_W'(q);
        r.wt   = WEIGHT_W'($urandom);
        r.hold = hold || ($urandom_range(0, 59) == 0);
        r.gap  = next_gap();
        request_backlog.push_back(r);
    endfunction

    // Pick a row that is completely stored (full) or not; -1 if none
    function automatic int pick_row(bit full);
        int start, j, pol;
        start = $urandom_range(0, POL_BINS - 1);
        for (j = 0; j < POL_BINS; j++) begin
            pol = (start + j) % POL_BINS;
            if ((row_stored[pol] == AZ_BINS) == full)
                return pol;
        end
        return -1;
    endfunction

    // Store every cell of a row in shuffled order
    function automatic void fill_row(int pol, bit fixed, logic signed [WEIGHT_W-1:0] w);
        int order [AZ_BINS];
        int j, k, t;
        for (j = 0; j < AZ_BINS; j++)
            order[j] = j;
        for (j = AZ_BINS - 1; j > 0; j--) begin
            k        = $urandom_range(0, j);
            t        = order[j];
            order[j] = order[k];
            order[k] = t;
        end
        for (j = 0; j < AZ_BINS; j++)
            add_store(order[j], pol, fixed ? w : rand_weight(), 1'b0);
    endfunction

    // Mostly queries on complete rows; row fills, overwrites, scattered stores
    // and out-of-limit harmonics mixed in. Never query an incomplete row with
    // a harmonic that would walk it.
    function automatic void random_phase(int n_items);
        int done, sel, pol, k, j, q;
        done = 0;
        while (done < n_items) begin
            sel = $urandom_range(0, 99);
            if (sel < 3) begin
                pol = pick_row(1'b0);
                if (pol >= 0) begin
                    fill_row(pol, 1'b0, '0);
                    done += AZ_BINS;
                end
            end else if (sel < 25) begin
                k = $urandom_range(1, 3);
                for (j = 0; j < k; j++) begin
                    pol = ($urandom_range(0, 1) == 1) ? pick_row(1'b1) : -1;
                    if (pol < 0)
                        pol = $urandom_range(0, POL_BINS - 1);
                    add_store($urandom_range(0, AZ_BINS - 1), pol, rand_weight(), 1'b0);
                end
                done += k;
            end else if (sel < 33 && harm_limit < 31) begin
                add_query($urandom_range(0, POL_BINS - 1),
                          $urandom_range(int'(harm_limit) + 1, 31), 1'b0);
                done++;
            end else begin
                k = $urandom_range(1, 3);
                for (j = 0; j < k; j++) begin
                    q = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31)
                                                    : $urandom_range(0, int'(harm_limit));
                    add_query(pick_row(1'b1), q, 1'b0);
                end
                done += k;
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Configuration writes and phase control
    // ------------------------------------------------------------------

    // Setup cycle, then access cycle; the register takes the value at the edge
    // that sees psel and penable high. Noise in the upper data bits is ignored.
    task automatic apb_write(int idx, logic [HARM_W-1:0] value);
        logic [afc_pkg::CFG_DATA_W-1:0] word;
        word             = $urandom;
        word[HARM_W-1:0] = value;
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx * 4);
        pwdata  <= word;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == afc_pkg::CFG_IDX_MAX_HARMONIC)
            harm_limit = word[HARM_W-1:0];
        @(negedge aclk);
    endtask

    // Wait until every request went out and every result came back, then let
    // the block settle before anything touches its configuration.
    task automatic drain_and_settle();
        do
            @(negedge aclk);
        while (request_backlog.size() != 0 || s_valid || n_checked != n_predicted);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------

    // Predict on acceptance, then present the next request once its gap is
    // spent. A held request waits until every outstanding result is back.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_wait = 0;
        end else begin
            if (s_valid && s_ready)
                apply_request(presented);
            if (!s_valid || s_ready) begin
                if (request_backlog.size() == 0 ||
                    (request_backlog[0].hold && n_predicted != n_checked)) begin
                    s_valid <= 1'b0;
                end else if (tx_wait < request_backlog[0].gap) begin
                    tx_wait++;
                    s_valid <= 1'b0;
                end else begin
                    presented = request_backlog.pop_front();
                    tx_wait   = 0;
                    s_op          <= presented.op;
                    s_azimuth_bin <= presented.az;
                    s_polar_bin   <= presented.pol;
                    s_harmonic    <= presented.harm;
                    s_weight      <= presented.wt;
                    s_valid       <= 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------

    function automatic void check_field(string what, logic [COEF_W-1:0] want,
                                        logic [COEF_W-1:0] got);
        if (got !== want) begin
            n_errors++;
            if (n_errors <= ERR_PRINT_MAX)
                $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
        end
    endfunction

    // Compare each accepted result with the oldest prediction, then pick the
    // next ready value: steady high, or random stalls of mixed length.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_stall = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_coefs.size() == 0) begin
                    n_errors++;
                    if (n_errors <= ERR_PRINT_MAX)
                        $display("%0t: result with no query outstanding, expected none, actual %h %h %b",
                                 $time, m_cos_coef, m_sin_coef, m_bad_harmonic);
                end else begin
                    oldest = expected_coefs.pop_front();
                    n_checked <= n_checked + 1;
                    check_field("cos_coef", oldest.cos_v, m_cos_coef);
                    check_field("sin_coef", oldest.sin_v, m_sin_coef);
                    check_field("bad_harmonic", COEF_W'(oldest.bad), COEF_W'(m_bad_harmonic));
                end
            end
            if (rx_steady) begin
                m_ready <= 1'b1;
            end else if (rx_stall > 0) begin
                rx_stall--;
                m_ready <= 1'b0;
            end else if ($urandom_range(0, 4) == 0) begin
                rx_stall = random_idle() - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run if nothing moves for too long
    // ------------------------------------------------------------------

    initial begin : watchdog
        int stuck;
        stuck = 0;
        while (stuck < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (psel && penable))
                stuck = 0;
            else
                stuck++;
        end
        $display("%0t: no request or result accepted for %0d cycles", $time, STALL_LIMIT);
        $display("angular_fourier_coefficients regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------

    initial begin : stimulus
        int limit_plan [6] = '{31, 0, 13, 20, 31, 8};
        int p;
        build_angle_table();
        harm_limit = afc_pkg::MAX_HARMONIC_RST;
        tx_steady  = 1'b0;
        rx_steady  = 1'b0;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part at the reset limit: rows of all-maximum and all-minimum
        // weights give the largest coefficients; probe harmonic zero, the limit,
        // one past it, and the top harmonic against a row never stored.
        fill_row(0, 1'b1, W_MAX);
        fill_row(POL_BINS - 1, 1'b1, W_MIN);
        add_query(0, 0, 1'b0);
        add_query(0, 1, 1'b0);
        add_query(0, int'(harm_limit), 1'b0);
        add_query(0, int'(harm_limit) + 1, 1'b0);
        add_query(POL_BINS - 1, 0, 1'b0);
        add_query(POL_BINS - 1, 5, 1'b0);
        add_query(17, 31, 1'b0);
        add_store(AZ_BINS - 1, POL_BINS - 1, W_MAX, 1'b0);
        add_query(POL_BINS - 1, 1, 1'b1);
        drain_and_settle();

        // Write to the spare index: the limit must stay where it was
        apb_write(IDX_SPARE, 5'd31);
        add_query(0, 9, 1'b0);
        add_query(POL_BINS - 1, 8, 1'b0);
        drain_and_settle();

        // Top limit: the highest harmonic walks the row
        apb_write(afc_pkg::CFG_IDX_MAX_HARMONIC, 5'd31);
        add_query(0, 31, 1'b0);
        add_query(POL_BINS - 1, 31, 1'b0);
        add_query(POL_BINS - 1, 16, 1'b0);
        drain_and_settle();

        // Bottom limit: only harmonic zero is allowed
        apb_write(afc_pkg::CFG_IDX_MAX_HARMONIC, 5'd0);
        add_query(0, 0, 1'b0);
        add_query(0, 1, 1'b0);
        add_query(POL_BINS - 1, 0, 1'b0);
        drain_and_settle();

        // Random phases, one limit each; first phase without idling, second
        // with idling on both sides, the rest mixed.
        for (p = 0; p < 6; p++) begin
            if (p == 3)
                limit_plan[p] = $urandom_range(1, 30);
            apb_write(afc_pkg::CFG_IDX_MAX_HARMONIC, HARM_W'(limit_plan[p]));
            tx_steady = (p == 0) ? 1'b1 : (p == 1) ? 1'b0 : 1'($urandom_range(0, 1));
            rx_steady = (p == 0) ? 1'b1 : (p == 1) ? 1'b0 : 1'($urandom_range(0, 1));
            random_phase(165);
            drain_and_settle();
        end

        if (expected_coefs.size() != 0) begin
            n_errors++;
            $display("%0t: %0d coefficient sets never returned", $time, expected_coefs.size());
        end
        if (n_errors == 0)
            $display("angular_fourier_coefficients regression: pass");
        else
            $display("angular_fourier_coefficients regression: fail");
        $finish;
    end

endmodule
